FILE: design/ialp_pkg.sv
// ----------------------------------------------------------------------------
// ialp_pkg
// Types, character codes and parse phase codes shared by the address literal
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ialp_pkg;

    // Address bytes, byte 0 first; as a vector byte 0 is the most significant
    typedef logic [0:15][7:0] t_bytes;

    typedef logic [2:0] t_phase;

    localparam t_phase PH_START       = 3'd0;
    localparam t_phase PH_LEAD_COLON  = 3'd1;
    localparam t_phase PH_GROUP       = 3'd2;
    localparam t_phase PH_AFTER_COLON = 3'd3;
    localparam t_phase PH_AFTER_GAP   = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    localparam logic [11:0] OCTET_MAX   = 12'd255;
    localparam logic [9:0]  OCTET_SAT   = 10'd256;
    localparam logic [4:0]  TAIL_LIMIT  = 5'd12;
    localparam logic [4:0]  GROUP_LIMIT = 5'd14;
    localparam logic [5:0]  BYTES_FULL  = 6'd16;
    localparam logic [7:0]  BYTE_ONES   = 8'hFF;

    // Parse state after the last character of a literal
    typedef struct packed {
        t_bytes      bytes;
        logic [4:0]  filled;
        logic [4:0]  gap_off;
        logic        gap_present;
        logic [15:0] group_hex;
        logic [7:0]  octet;
        logic        has_digits;
        logic        in_tail;
        logic [1:0]  octet_idx;
        t_phase      phase;
        logic        failed;
        logic        colon_seen;
    } t_snap;

    typedef struct packed {
        logic        addr_ok;
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_result;

    // {valid, value} of a hex digit character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/ip_address_literal_parser.sv
// ----------------------------------------------------------------------------
// ip_address_literal_parser
// Parses an IPv4 or IPv6 address literal, one character per item, into a
// validity flag, an IPv6 flag and a 128-bit address.
// Throughput: one character per cycle, no gaps between literals; a last
// character waits while a pending result is held by a stalled output.
// Path: input register, character scan, assembly into the output register.
// Reset: synchronous, active low; clears the handshake and parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_address_literal_parser import ialp_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // char_code
    input  wire logic         i_s_tlast,   // last_char
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [127:0]      o_m_tdata,   // addr_high [63:0], addr_low [127:64]
    output logic [1:0]        o_m_tuser    // addr_ok [0], is_ipv6 [1]
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_fin_valid;
    t_snap      r_fin;
    logic       r_out_valid;
    t_result    r_out;

    t_snap      snap;
    t_result    res;
    logic       out_free;
    logic       fin_adv;
    logic       fin_free;
    logic       in_adv;

    // Only a last character needs room downstream; others always advance
    assign out_free   = !r_out_valid || i_m_tready;
    assign fin_adv    = r_fin_valid && out_free;
    assign fin_free   = !r_fin_valid || fin_adv;
    assign in_adv     = r_in_valid && (!r_in_last || fin_free);
    assign o_s_tready = !r_in_valid || in_adv;

    ialp_scanner u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_adv),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_snap  (snap)
    );

    ialp_assemble u_assemble (
        .i_snap (r_fin),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (fin_free) begin
                r_fin_valid <= in_adv && r_in_last;
            end
            if (out_free) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (in_adv && r_in_last) begin
            r_fin <= snap;
        end
        if (fin_adv) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.addr_low, r_out.addr_high};
    assign o_m_tuser  = {r_out.is_ipv6, r_out.addr_ok};

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 128'd0 && !o_m_tuser[1])
        else $error("invalid literal gave a non-zero result");

    a_ipv4_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] && !o_m_tuser[1] |-> o_m_tdata[127:96] == 32'd0 &&
        o_m_tdata[63:0] == 64'd0)
        else $error("IPv4 result outside the low 32 bits");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv && r_in_last |=> r_fin_valid)
        else $error("last character did not produce a pending result");

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !out_free |=> r_fin_valid && $stable(r_fin))
        else $error("pending result changed while the output was stalled");

endmodule

`default_nettype wire

FILE: design/ialp_scanner.sv
// ----------------------------------------------------------------------------
// ialp_scanner
// Per-character parse state: hex groups, '::' gap, dotted-quad tail and the
// address bytes gathered so far. Gives the state after the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module ialp_scanner import ialp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_char,
    input  wire logic       i_last,
    output t_snap           o_snap
);

    t_bytes      r_bytes,     n_bytes;
    logic [4:0]  r_filled,    n_filled;
    logic [4:0]  r_gap_off,   n_gap_off;
    logic        r_gap,       n_gap;
    logic [15:0] r_hex,       n_hex;
    logic [9:0]  r_octet,     n_octet;
    logic [2:0]  r_dcnt,      n_dcnt;
    logic        r_all_dec,   n_all_dec;
    logic        r_lead_zero, n_lead_zero;
    logic        r_tail,      n_tail;
    logic [1:0]  r_oidx,      n_oidx;
    t_phase      r_phase,     n_phase;
    logic        r_failed,    n_failed;
    logic        r_colon,     n_colon;

    logic [4:0]  hexv;
    logic        is_hex;
    logic        is_dec;
    logic        is_colon;
    logic        is_dot;
    logic [11:0] oct_next;
    logic        group_mode;
    logic        clr;
    logic        wr0, wr1;
    logic [3:0]  idx0, idx1;
    logic [7:0]  d0, d1;

    always_comb begin
        hexv     = hex_digit(i_char);
        is_hex   = hexv[4];
        is_dec   = i_char inside {[CH_ZERO:CH_NINE]};
        is_colon = (i_char == CH_COLON);
        is_dot   = (i_char == CH_DOT);
        oct_next = {2'b00, r_octet} * 12'd10 + {8'd0, hexv[3:0]};

        n_filled    = r_filled;
        n_gap_off   = r_gap_off;
        n_gap       = r_gap;
        n_hex       = r_hex;
        n_octet     = r_octet;
        n_dcnt      = r_dcnt;
        n_all_dec   = r_all_dec;
        n_lead_zero = r_lead_zero;
        n_tail      = r_tail;
        n_oidx      = r_oidx;
        n_phase     = r_phase;
        n_failed    = r_failed;
        n_colon     = r_colon | is_colon;
        group_mode  = 1'b0;
        clr         = 1'b0;
        wr0         = 1'b0;
        wr1         = 1'b0;
        idx0        = r_filled[3:0];
        idx1        = r_filled[3:0] + 4'd1;
        d0          = r_octet[7:0];
        d1          = r_hex[7:0];

        if (!r_failed) begin
            if (r_tail) begin
                if (is_dec) begin
                    if (r_dcnt == 3'd0) begin
                        n_lead_zero = (i_char == CH_ZERO);
                    end
                    if ((r_dcnt != 3'd0 && r_lead_zero) || r_dcnt >= 3'd3) begin
                        n_failed = 1'b1;
                    end else begin
                        n_dcnt  = r_dcnt + 3'd1;
                        n_octet = oct_next[9:0];
                        if (oct_next > OCTET_MAX) begin
                            n_failed = 1'b1;
                        end
                    end
                end else if (is_dot && r_dcnt != 3'd0 && r_oidx != 2'd3) begin
                    wr0    = 1'b1;
                    idx0   = r_filled[3:0] + {2'b00, r_oidx};
                    n_oidx = r_oidx + 2'd1;
                    clr    = 1'b1;
                end else begin
                    n_failed = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (is_colon) begin
                            n_phase = PH_LEAD_COLON;
                        end else begin
                            group_mode = 1'b1;
                        end
                    end
                    PH_LEAD_COLON: begin
                        if (is_colon) begin
                            n_gap     = 1'b1;
                            n_gap_off = 5'd0;
                            n_phase   = PH_AFTER_GAP;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    PH_AFTER_COLON: begin
                        if (is_colon) begin
                            if (r_gap) begin
                                n_failed = 1'b1;
                            end else begin
                                n_gap     = 1'b1;
                                n_gap_off = r_filled;
                                n_phase   = PH_AFTER_GAP;
                            end
                        end else begin
                            group_mode = 1'b1;
                        end
                    end
                    default: begin
                        group_mode = 1'b1;
                    end
                endcase

                if (group_mode) begin
                    if (is_hex) begin
                        if (r_dcnt == 3'd0) begin
                            n_lead_zero = (i_char == CH_ZERO);
                        end
                        if (r_dcnt >= 3'd4) begin
                            n_failed = 1'b1;
                        end else begin
                            n_dcnt  = r_dcnt + 3'd1;
                            n_hex   = {r_hex[11:0], hexv[3:0]};
                            n_phase = PH_GROUP;
                            if (is_dec) begin
                                n_octet = (oct_next > OCTET_MAX) ? OCTET_SAT
                                                                 : oct_next[9:0];
                            end else begin
                                n_all_dec = 1'b0;
                            end
                        end
                    end else if (is_dot && r_dcnt != 3'd0) begin
                        // first octet of an embedded dotted quad
                        if (r_filled > TAIL_LIMIT || !r_all_dec || r_dcnt > 3'd3 ||
                            r_octet > OCTET_MAX[9:0] ||
                            (r_lead_zero && r_dcnt > 3'd1)) begin
                            n_failed = 1'b1;
                        end else begin
                            wr0    = 1'b1;
                            n_oidx = 2'd1;
                            n_tail = 1'b1;
                            clr    = 1'b1;
                        end
                    end else if (is_colon && r_dcnt != 3'd0) begin
                        if (r_filled > GROUP_LIMIT) begin
                            n_failed = 1'b1;
                        end else begin
                            wr0      = 1'b1;
                            wr1      = 1'b1;
                            d0       = r_hex[15:8];
                            n_filled = r_filled + 5'd2;
                            clr      = 1'b1;
                            n_phase  = PH_AFTER_COLON;
                        end
                    end else begin
                        n_failed = 1'b1;
                    end
                end
            end
        end

        if (clr) begin
            n_hex       = 16'd0;
            n_octet     = 10'd0;
            n_dcnt      = 3'd0;
            n_all_dec   = 1'b1;
            n_lead_zero = 1'b0;
        end

        n_bytes = r_bytes;
        if (wr0) begin
            n_bytes[idx0] = d0;
        end
        if (wr1) begin
            n_bytes[idx1] = d1;
        end
    end

    always_comb begin
        o_snap.bytes       = n_bytes;
        o_snap.filled      = n_filled;
        o_snap.gap_off     = n_gap_off;
        o_snap.gap_present = n_gap;
        o_snap.group_hex   = n_hex;
        o_snap.octet       = n_octet[7:0];
        o_snap.has_digits  = (n_dcnt != 3'd0);
        o_snap.in_tail     = n_tail;
        o_snap.octet_idx   = n_oidx;
        o_snap.phase       = n_phase;
        o_snap.failed      = n_failed;
        o_snap.colon_seen  = n_colon;
    end

    // Bytes below the fill count are always written before they are read
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_bytes <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_filled    <= 5'd0;
            r_gap_off   <= 5'd0;
            r_gap       <= 1'b0;
            r_hex       <= 16'd0;
            r_octet     <= 10'd0;
            r_dcnt      <= 3'd0;
            r_all_dec   <= 1'b1;
            r_lead_zero <= 1'b0;
            r_tail      <= 1'b0;
            r_oidx      <= 2'd0;
            r_phase     <= PH_START;
            r_failed    <= 1'b0;
            r_colon     <= 1'b0;
        end else if (i_step) begin
            r_filled    <= n_filled;
            r_gap_off   <= n_gap_off;
            r_gap       <= n_gap;
            r_hex       <= n_hex;
            r_octet     <= n_octet;
            r_dcnt      <= n_dcnt;
            r_all_dec   <= n_all_dec;
            r_lead_zero <= n_lead_zero;
            r_tail      <= n_tail;
            r_oidx      <= n_oidx;
            r_phase     <= n_phase;
            r_failed    <= n_failed;
            r_colon     <= n_colon;
        end
    end

endmodule

`default_nettype wire

FILE: design/ialp_assemble.sv
// ----------------------------------------------------------------------------
// ialp_assemble
// Closes the final group or dotted tail, expands the '::' gap, checks the
// shape and folds IPv4-mapped addresses back to IPv4.
// ----------------------------------------------------------------------------
`default_nettype none

module ialp_assemble import ialp_pkg::*; (
    input  wire t_snap i_snap,
    output t_result    o_res
);

    logic         tail_done;
    logic         group_open;
    logic         shape_ok;
    logic [5:0]   bf2;
    logic [5:0]   s6;
    logic [5:0]   gs;
    t_bytes       bytes2;
    t_bytes       full;
    logic [127:0] vec;
    logic [127:0] pre_mask;
    logic [127:0] post_mask;
    logic         valid;
    logic         mapped;

    always_comb begin
        tail_done  = i_snap.in_tail && i_snap.octet_idx == 2'd3 && i_snap.has_digits;
        group_open = !i_snap.in_tail && i_snap.phase == PH_GROUP;

        bytes2 = i_snap.bytes;
        if (tail_done) begin
            bytes2[i_snap.filled[3:0] + 4'd3] = i_snap.octet;
        end else if (group_open) begin
            bytes2[i_snap.filled[3:0]]        = i_snap.group_hex[15:8];
            bytes2[i_snap.filled[3:0] + 4'd1] = i_snap.group_hex[7:0];
        end

        if (tail_done) begin
            bf2 = {1'b0, i_snap.filled} + 6'd4;
        end else if (group_open) begin
            bf2 = {1'b0, i_snap.filled} + 6'd2;
        end else begin
            bf2 = {1'b0, i_snap.filled};
        end

        shape_ok = tail_done ||
                   (group_open && i_snap.filled <= GROUP_LIMIT) ||
                   (!i_snap.in_tail && i_snap.phase == PH_AFTER_GAP);

        // Gap expansion: keep the bytes before the gap, slide the rest to the end
        s6        = BYTES_FULL - bf2;
        gs        = {1'b0, i_snap.gap_off} + s6;
        vec       = bytes2;
        pre_mask  = ~({128{1'b1}} >> {i_snap.gap_off, 3'b000});
        post_mask = {128{1'b1}} >> {gs[4:0], 3'b000};

        valid = 1'b0;
        full  = bytes2;
        if (!i_snap.failed && i_snap.colon_seen && shape_ok && bf2 <= BYTES_FULL) begin
            if (i_snap.gap_present) begin
                if (bf2 != BYTES_FULL && {1'b0, i_snap.gap_off} <= bf2) begin
                    valid = 1'b1;
                    full  = (vec & pre_mask) | ((vec >> {s6[4:0], 3'b000}) & post_mask);
                end
            end else begin
                valid = (bf2 == BYTES_FULL);
            end
        end

        mapped = (full[0:9] == 80'd0) && full[10] == BYTE_ONES && full[11] == BYTE_ONES;

        o_res.addr_ok   = 1'b0;
        o_res.is_ipv6   = 1'b0;
        o_res.addr_high = 64'd0;
        o_res.addr_low  = 64'd0;
        if (!i_snap.failed && !i_snap.colon_seen) begin
            if (tail_done) begin
                o_res.addr_ok  = 1'b1;
                o_res.addr_low = {32'd0, bytes2[0:3]};
            end
        end else if (valid) begin
            o_res.addr_ok = 1'b1;
            if (mapped) begin
                o_res.addr_low = {32'd0, full[12:15]};
            end else begin
                o_res.is_ipv6   = 1'b1;
                o_res.addr_high = full[0:7];
                o_res.addr_low  = full[8:15];
            end
        end
    end

endmodule

`default_nettype wire
